[hdl/bba_pkg.sv]
// shared constants, codes and helpers of the bitmap block allocator
`default_nettype none

package bba_pkg;

	localparam int BBA_BLOCKS_DEF = 1024;
	localparam int INDEX_LIMIT    = 1024;
	localparam int BLK_W          = 10;
	localparam int OP_W           = 2;
	localparam int ST_W           = 2;
	localparam int WORD_W         = 32;
	localparam int OFF_W          = 5;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	localparam op_t OP_ALLOCATE = 2'd0;
	localparam op_t OP_RELEASE  = 2'd1;
	localparam op_t OP_GROW     = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_NO_SPACE = 2'd2;

	// position of the lowest set bit, zero when none is set
	function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [OFF_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = OFF_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

[hdl/bba_map_mem.sv]
// used/free map memory, 32-bit words, registered read, per-word valid bits
`default_nettype none

module bba_map_mem #(
	parameter int BLOCKS = bba_pkg::BBA_BLOCKS_DEF,
	localparam int USABLE = (BLOCKS < bba_pkg::INDEX_LIMIT) ? BLOCKS : bba_pkg::INDEX_LIMIT,
	localparam int WORDS = (USABLE + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rd_en,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               addr,
	input  wire logic [bba_pkg::WORD_W-1:0]  wdata,
	output logic      [bba_pkg::WORD_W-1:0]  rdata
);
	import bba_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rd_word_q;
	logic [WORDS-1:0]  valid_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rd_word_q <= mem[addr];
		end
	end

	// a word never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_word_q : '0;

endmodule

`default_nettype wire

[hdl/bba_ctrl.sv]
// request sequencer: word-by-word read-modify-write over the map
`default_nettype none

module bba_ctrl #(
	parameter int BLOCKS = bba_pkg::BBA_BLOCKS_DEF,
	localparam int USABLE = (BLOCKS < bba_pkg::INDEX_LIMIT) ? BLOCKS : bba_pkg::INDEX_LIMIT,
	localparam int WORDS = (USABLE + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire bba_pkg::op_t                in_op,
	input  wire logic [bba_pkg::BLK_W-1:0]   in_first,
	input  wire logic [bba_pkg::BLK_W-1:0]   in_last,
	input  wire logic [bba_pkg::BLK_W-1:0]   in_extra,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output bba_pkg::status_t                 res_status,
	output logic      [bba_pkg::BLK_W-1:0]   res_index,
	output logic                             mem_rd_en,
	output logic                             mem_wr_en,
	output logic      [AW-1:0]               mem_addr,
	output logic      [bba_pkg::WORD_W-1:0]  mem_wdata,
	input  wire logic [bba_pkg::WORD_W-1:0]  mem_rdata
);
	import bba_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_MOD  = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	localparam logic [BLK_W:0]    USABLE_X = (BLK_W + 1)'(USABLE);
	localparam logic [BLK_W-1:0]  TOP_BLK  = BLK_W'(USABLE - 1);
	localparam logic [WORD_W-1:0] ONES     = '1;
	localparam logic [OFF_W-1:0]  OFF_MAX  = '1;

	function automatic logic [AW-1:0] word_of(input logic [BLK_W-1:0] blk);
		logic [BLK_W-1:0] s;
		s = blk >> OFF_W;
		return s[AW-1:0];
	endfunction

	state_t            state_q;
	op_t               op_q;
	logic [BLK_W-1:0]  lo_q, hi_q;
	logic [AW-1:0]     w_q;
	logic              mark_q;
	status_t           status_q;
	logic [BLK_W-1:0]  index_q;

	logic [AW-1:0]     lo_w, hi_w;
	logic [OFF_W-1:0]  lo_off, hi_off, pos;
	logic [WORD_W-1:0] mask, free_bits;
	logic              free_any, used_hit, last_word;
	logic [BLK_W:0]    sum;

	always_comb begin
		lo_w      = word_of(lo_q);
		hi_w      = word_of(hi_q);
		lo_off    = (w_q == lo_w) ? lo_q[OFF_W-1:0] : '0;
		hi_off    = (w_q == hi_w) ? hi_q[OFF_W-1:0] : OFF_MAX;
		mask      = (ONES << lo_off) & (ONES >> (OFF_MAX - hi_off));
		free_bits = ~mem_rdata & mask;
		free_any  = |free_bits;
		used_hit  = |(mem_rdata & mask);
		pos       = lowest_set(free_bits);
		last_word = (w_q == hi_w);
		sum       = {1'b0, in_last} + {1'b0, in_extra};
	end

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_RESP);
	assign res_status = status_q;
	assign res_index  = index_q;
	assign mem_rd_en  = (state_q == S_RD);
	assign mem_addr   = w_q;

	always_comb begin
		mem_wr_en = 1'b0;
		mem_wdata = mem_rdata;
		if (state_q == S_MOD) begin
			case (op_q)
				OP_ALLOCATE: begin
					mem_wr_en = free_any;
					mem_wdata = mem_rdata | (WORD_W'(1) << pos);
				end
				OP_RELEASE: begin
					mem_wr_en = 1'b1;
					mem_wdata = mem_rdata & ~mask;
				end
				OP_GROW: begin
					mem_wr_en = mark_q;
					mem_wdata = mem_rdata | mask;
				end
				default: begin
					mem_wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_ALLOCATE;
			lo_q     <= '0;
			hi_q     <= '0;
			w_q      <= '0;
			mark_q   <= 1'b0;
			status_q <= ST_OK;
			index_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_op;
						mark_q   <= 1'b0;
						status_q <= ST_OK;
						index_q  <= '0;
						state_q  <= S_RESP;
						case (in_op)
							OP_ALLOCATE: begin
								lo_q    <= '0;
								hi_q    <= TOP_BLK;
								w_q     <= '0;
								state_q <= S_RD;
							end
							OP_RELEASE: begin
								if (in_first <= in_last && {1'b0, in_first} < USABLE_X) begin
									lo_q    <= in_first;
									hi_q    <= ({1'b0, in_last} < USABLE_X) ? in_last : TOP_BLK;
									w_q     <= word_of(in_first);
									state_q <= S_RD;
								end
							end
							OP_GROW: begin
								if (in_extra == '0) begin
									index_q <= in_last;
								end else if (sum >= USABLE_X) begin
									status_q <= ST_NO_SPACE;
								end else begin
									lo_q    <= in_last + BLK_W'(1);
									hi_q    <= sum[BLK_W-1:0];
									w_q     <= word_of(in_last + BLK_W'(1));
									state_q <= S_RD;
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					state_q <= S_RD;
					w_q     <= w_q + AW'(1);
					case (op_q)
						OP_ALLOCATE: begin
							if (free_any) begin
								index_q <= (BLK_W'(w_q) << OFF_W) | BLK_W'(pos);
								state_q <= S_RESP;
							end else if (last_word) begin
								status_q <= ST_FULL;
								state_q  <= S_RESP;
							end
						end
						OP_RELEASE: begin
							if (last_word) begin
								state_q <= S_RESP;
							end
						end
						OP_GROW: begin
							if (!mark_q && used_hit) begin
								status_q <= ST_NO_SPACE;
								state_q  <= S_RESP;
							end else if (!mark_q && last_word) begin
								// range is free: second pass marks it
								mark_q <= 1'b1;
								w_q    <= lo_w;
							end else if (last_word) begin
								index_q <= hi_q;
								state_q <= S_RESP;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/bitmap_block_allocator.sv]
// top level of the bitmap block allocator
//
//   channel  | direction | tdata                                       | tuser
//   s_*      | request   | first_block, last_block, extra_blocks       | operation
//   m_*      | response  | block_index                                 | status
//
// one request at a time; the map sits in 32-bit words of one memory port
// each touched word is read, then modified and written back
// allocate scans words from the lowest until a free block is found or the map ends
// release visits every word covered; grow: test pass then mark pass over the range
// reset clears the map at once through per-word valid bits, no clearing pass
// a held response does not block acceptance of the next request
`default_nettype none

module bitmap_block_allocator #(
	parameter int BLOCKS = bba_pkg::BBA_BLOCKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // first_block[9:0], last_block[19:10], extra_blocks[29:20]
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // block_index[9:0]
	output logic      [1:0]  m_tuser    // status[1:0]
);
	import bba_pkg::*;

	localparam int USABLE = (BLOCKS < INDEX_LIMIT) ? BLOCKS : INDEX_LIMIT;
	localparam int WORDS  = (USABLE + WORD_W - 1) / WORD_W;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic              res_valid, res_ready;
	status_t           res_status;
	logic [BLK_W-1:0]  res_index;
	logic              mem_rd_en, mem_wr_en;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	// output register
	logic              m_valid_q;
	status_t           m_status_q;
	logic [BLK_W-1:0]  m_index_q;

	bba_ctrl #(
		.BLOCKS(BLOCKS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_first   (s_tdata[9:0]),
		.in_last    (s_tdata[19:10]),
		.in_extra   (s_tdata[29:20]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_status (res_status),
		.res_index  (res_index),
		.mem_rd_en  (mem_rd_en),
		.mem_wr_en  (mem_wr_en),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	bba_map_mem #(
		.BLOCKS(BLOCKS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (mem_rd_en),
		.wr_en  (mem_wr_en),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	// result moves into the output register when it is empty or being drained
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_status_q <= res_status;
			m_index_q  <= res_index;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {6'd0, m_index_q};

endmodule

`default_nettype wire

[hdl/bba_checker.sv]
// port-level checks for the bitmap block allocator, bound to the top level
`default_nettype none

module bba_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import bba_pkg::*;

	// stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("response changed while stalled");

	// only one request in work at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// failed requests carry index zero
	a_fail_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_NO_SPACE) |-> m_tdata[9:0] == 10'd0)
		else $error("nonzero index on failed request");

	// status code and padding stay legal
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_NO_SPACE)
			&& m_tdata[15:10] == 6'd0)
		else $error("illegal status or padding");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
